FILE: rtl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared types and constants for the ready-queue scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int QDEPTH = 16;
  localparam int IDX_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 2);

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_RR    = 2'd2,
    POL_AGING = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_RAN   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [0:0] REG_POLICY  = 1'b0;
  localparam logic [0:0] REG_QUANTUM = 1'b1;

  localparam logic [5:0] QUANTUM_RST = 6'd2;

  // one table entry
  typedef struct packed {
    logic [7:0] id;
    logic [9:0] start;
    logic [9:0] len;
    logic [9:0] prog;
    logic [9:0] score;
  } entry_t;

endpackage

FILE: rtl/rqs_if.sv
// ----------------------------------------------------------------------------
// rqs request and result channels
// Valid/ready channels carrying scheduler requests and results.
// ----------------------------------------------------------------------------
interface rqs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] job_id;
  logic [9:0] start_pos;
  logic [9:0] job_length;
  logic [9:0] aging_score;
  modport source (output valid, cmd, job_id, start_pos, job_length, aging_score,
                  input ready);
  modport sink   (input valid, cmd, job_id, start_pos, job_length, aging_score,
                  output ready);
endinterface

interface rqs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] ran_id;
  logic [10:0] line_address;
  logic       finished;
  logic [4:0] job_count;
  modport source (output valid, status, ran_id, line_address, finished, job_count,
                  input ready);
  modport sink   (input valid, status, ran_id, line_address, finished, job_count,
                  output ready);
endinterface

FILE: rtl/ready_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// ready_queue_scheduler_core
// Job table with first come, shortest job, round robin and aging selection.
// ----------------------------------------------------------------------------
// One request at a time. The job table is a 16-entry memory with one write
// port and two registered read ports, walked by a small sequencer; every move
// of an entry is a read followed by a write. An add scans the entries under
// shortest job and then moves entries to open the slot. A step reads the
// chosen entry and, when the job finishes, removes it and moves the entries
// behind it; under aging it adds two exchange sorts (120 compared pairs at a
// full table) and a decrement pass over the entries. Results sit in an output
// register; a new request is taken once the previous one is done, and a
// stalled result holds the block until it leaves.
module ready_queue_scheduler_core (
  input  logic         clk,
  input  logic         rst_n,
  rqs_in_if.sink       in_ch,
  rqs_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_INS, S_INS_WR, S_RUN_RD, S_RUN,
    S_REM, S_REM_WR, S_DEC, S_DEC_WR, S_SORT, S_SORT_CMP, S_SORT_SW, S_DONE
  } state_t;

  localparam logic [rqs_pkg::CNT_W-1:0] DEPTH_C = rqs_pkg::CNT_W'(rqs_pkg::QDEPTH);
  localparam logic [rqs_pkg::CNT_W-1:0] ONE_C   = rqs_pkg::CNT_W'(1);

  state_t state_r, state_nxt;
  logic [1:0]  policy_r, policy_nxt;
  logic [5:0]  quantum_r, quantum_nxt;
  logic [rqs_pkg::CNT_W-1:0] occ_r, occ_nxt;
  logic [rqs_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [5:0]  turn_r, turn_nxt;
  logic [rqs_pkg::CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, pos_r, pos_nxt;
  logic [rqs_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic        prog0_nz_r, prog0_nz_nxt;
  logic        post_r, post_nxt;
  logic        cmd_r, cmd_nxt;
  rqs_pkg::entry_t new_r, new_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [7:0]  res_id_r, res_id_nxt;
  logic [10:0] res_addr_r, res_addr_nxt;
  logic        res_fin_r, res_fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_id_r, out_id_nxt;
  logic [10:0] out_addr_r, out_addr_nxt;
  logic        out_fin_r, out_fin_nxt;
  logic [4:0]  out_count_r, out_count_nxt;

  // table memory
  rqs_pkg::entry_t mem [rqs_pkg::QDEPTH];
  rqs_pkg::entry_t rd_a_r, rd_b_r, wdata;
  logic [rqs_pkg::IDX_W-1:0] ra, rb, wa;
  logic re, we;

  logic in_fire, cfg_wr;
  logic [rqs_pkg::CNT_W-1:0] pos_t, occ_m1;
  logic [rqs_pkg::IDX_W-1:0] h_t;
  logic [9:0]  prog_inc;
  logic [5:0]  turn_inc;
  rqs_pkg::entry_t ent_t;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rqs_pkg::REG_QUANTUM) ? {26'd0, quantum_r}
                                                             : {30'd0, policy_r};
  assign occ_m1     = occ_r - ONE_C;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.ran_id       = out_id_r;
  assign out_ch.line_address = out_addr_r;
  assign out_ch.finished     = out_fin_r;
  assign out_ch.job_count    = out_count_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    policy_nxt = policy_r;
    quantum_nxt = quantum_r;
    occ_nxt = occ_r;
    head_nxt = head_r;
    turn_nxt = turn_r;
    i_nxt = i_r;
    j_nxt = j_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    prog0_nz_nxt = prog0_nz_r;
    post_nxt = post_r;
    cmd_nxt = cmd_r;
    new_nxt = new_r;
    res_status_nxt = res_status_r;
    res_id_nxt = res_id_r;
    res_addr_nxt = res_addr_r;
    res_fin_nxt = res_fin_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt = out_id_r;
    out_addr_nxt = out_addr_r;
    out_fin_nxt = out_fin_r;
    out_count_nxt = out_count_r;
    ra = '0;
    rb = '0;
    re = 1'b0;
    wa = '0;
    we = 1'b0;
    wdata = rd_a_r;
    pos_t = pos_r;
    h_t = head_r;
    prog_inc = rd_a_r.prog + 10'd1;
    turn_inc = turn_r + 6'd1;
    ent_t = rd_a_r;

    if (cfg_wr) begin
      if (cfg_paddr[2] == rqs_pkg::REG_POLICY) begin
        policy_nxt = cfg_pwdata[1:0];
      end else begin
        quantum_nxt = cfg_pwdata[5:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_ch.cmd;
          new_nxt = '{id: in_ch.job_id, start: in_ch.start_pos, len: in_ch.job_length,
                      prog: 10'd0, score: in_ch.aging_score};
          res_id_nxt = '0;
          res_addr_nxt = '0;
          res_fin_nxt = 1'b0;
          if (in_ch.cmd == rqs_pkg::CMD_ADD) begin
            if (occ_r >= DEPTH_C) begin
              res_status_nxt = rqs_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else if (policy_r == rqs_pkg::POL_SJF && occ_r != '0) begin
              pos_nxt = '0;
              i_nxt = '0;
              state_nxt = S_SCAN_RD;
            end else begin
              pos_nxt = (policy_r == rqs_pkg::POL_SJF) ? '0 : occ_r;
              i_nxt = occ_r;
              state_nxt = S_INS;
            end
          end else if (occ_r == '0) begin
            res_status_nxt = rqs_pkg::ST_EMPTY;
            state_nxt = S_DONE;
          end else if (policy_r == rqs_pkg::POL_RR) begin
            h_t = ({1'b0, head_r} >= occ_r) ? '0 : head_r;
            head_nxt = h_t;
            idx_nxt = h_t;
            state_nxt = S_RUN_RD;
          end else if (policy_r == rqs_pkg::POL_AGING) begin
            i_nxt = '0;
            j_nxt = ONE_C;
            post_nxt = 1'b0;
            state_nxt = S_SORT;
          end else begin
            idx_nxt = '0;
            state_nxt = S_RUN_RD;
          end
        end
      end

      // shortest job: find slot after last entry no longer than the new one
      S_SCAN_RD: begin
        ra = i_r[rqs_pkg::IDX_W-1:0];
        re = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rd_a_r.len <= new_r.len) begin
          pos_t = i_r + ONE_C;
        end
        if (i_r == '0) begin
          prog0_nz_nxt = (rd_a_r.prog != '0);
        end
        if (i_r + ONE_C >= occ_r) begin
          if (pos_t == '0 && ((i_r == '0) ? (rd_a_r.prog != '0) : prog0_nz_r)) begin
            pos_t = ONE_C;
          end
          i_nxt = occ_r;
          state_nxt = S_INS;
        end else begin
          i_nxt = i_r + ONE_C;
          state_nxt = S_SCAN_RD;
        end
        pos_nxt = pos_t;
      end

      // open a slot at pos by moving entries back one place
      S_INS: begin
        if (i_r > pos_r) begin
          ra = occ_m1[rqs_pkg::IDX_W-1:0] - (occ_r[rqs_pkg::IDX_W-1:0]
               - i_r[rqs_pkg::IDX_W-1:0]);
          re = 1'b1;
          state_nxt = S_INS_WR;
        end else begin
          we = 1'b1;
          wa = pos_r[rqs_pkg::IDX_W-1:0];
          wdata = new_r;
          if (occ_r != '0 && pos_r <= {1'b0, head_r} && pos_r < occ_r) begin
            head_nxt = head_r + 1'b1;
          end
          occ_nxt = occ_r + ONE_C;
          res_status_nxt = rqs_pkg::ST_ADDED;
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        we = 1'b1;
        wa = i_r[rqs_pkg::IDX_W-1:0];
        i_nxt = i_r - ONE_C;
        state_nxt = S_INS;
      end

      // run one line of the chosen entry
      S_RUN_RD: begin
        ra = idx_r;
        re = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        res_status_nxt = rqs_pkg::ST_RAN;
        res_id_nxt = rd_a_r.id;
        res_addr_nxt = {1'b0, rd_a_r.start} + {1'b0, rd_a_r.prog};
        if (prog_inc >= rd_a_r.len) begin
          res_fin_nxt = 1'b1;
          i_nxt = {1'b0, idx_r};
          state_nxt = S_REM;
        end else begin
          ent_t.prog = prog_inc;
          we = 1'b1;
          wa = idx_r;
          wdata = ent_t;
          if (policy_r == rqs_pkg::POL_RR) begin
            if (turn_inc >= quantum_r) begin
              turn_nxt = '0;
              head_nxt = ({1'b0, head_r} + ONE_C == occ_r) ? '0 : head_r + 1'b1;
            end else begin
              turn_nxt = turn_inc;
            end
          end
          if (policy_r == rqs_pkg::POL_AGING) begin
            i_nxt = ONE_C;
            state_nxt = S_DEC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // remove finished entry, pull the rest forward
      S_REM: begin
        if (i_r + ONE_C < occ_r) begin
          ra = i_r[rqs_pkg::IDX_W-1:0] + 1'b1;
          re = 1'b1;
          state_nxt = S_REM_WR;
        end else begin
          occ_nxt = occ_m1;
          h_t = (head_r > idx_r) ? head_r - 1'b1 : head_r;
          head_nxt = ({1'b0, h_t} >= occ_m1) ? '0 : h_t;
          if (policy_r == rqs_pkg::POL_RR) begin
            turn_nxt = '0;
          end
          if (policy_r == rqs_pkg::POL_AGING) begin
            i_nxt = '0;
            state_nxt = S_DEC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_REM_WR: begin
        we = 1'b1;
        wa = i_r[rqs_pkg::IDX_W-1:0];
        i_nxt = i_r + ONE_C;
        state_nxt = S_REM;
      end

      // aging: lower scores of waiting entries
      S_DEC: begin
        if (i_r < occ_r) begin
          ra = i_r[rqs_pkg::IDX_W-1:0];
          re = 1'b1;
          state_nxt = S_DEC_WR;
        end else begin
          i_nxt = '0;
          j_nxt = ONE_C;
          post_nxt = 1'b1;
          state_nxt = S_SORT;
        end
      end
      S_DEC_WR: begin
        if (rd_a_r.score != '0) begin
          ent_t.score = rd_a_r.score - 10'd1;
        end
        we = 1'b1;
        wa = i_r[rqs_pkg::IDX_W-1:0];
        wdata = ent_t;
        i_nxt = i_r + ONE_C;
        state_nxt = S_DEC;
      end

      // exchange sort by score
      S_SORT: begin
        if (i_r < occ_r) begin
          if (j_r < occ_r) begin
            ra = i_r[rqs_pkg::IDX_W-1:0];
            rb = j_r[rqs_pkg::IDX_W-1:0];
            re = 1'b1;
            state_nxt = S_SORT_CMP;
          end else begin
            i_nxt = i_r + ONE_C;
            j_nxt = i_r + ONE_C + ONE_C;
          end
        end else if (post_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = '0;
          state_nxt = S_RUN_RD;
        end
      end
      S_SORT_CMP: begin
        if (rd_a_r.score > rd_b_r.score) begin
          we = 1'b1;
          wa = i_r[rqs_pkg::IDX_W-1:0];
          wdata = rd_b_r;
          state_nxt = S_SORT_SW;
        end else begin
          j_nxt = j_r + ONE_C;
          state_nxt = S_SORT;
        end
      end
      S_SORT_SW: begin
        we = 1'b1;
        wa = j_r[rqs_pkg::IDX_W-1:0];
        wdata = rd_a_r;
        j_nxt = j_r + ONE_C;
        state_nxt = S_SORT;
      end

      // hand result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt = res_id_r;
          out_addr_nxt = res_addr_r;
          out_fin_nxt = res_fin_r;
          out_count_nxt = occ_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      policy_r <= rqs_pkg::POL_FCFS;
      quantum_r <= rqs_pkg::QUANTUM_RST;
      occ_r <= '0;
      head_r <= '0;
      turn_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      policy_r <= policy_nxt;
      quantum_r <= quantum_nxt;
      occ_r <= occ_nxt;
      head_r <= head_nxt;
      turn_r <= turn_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    prog0_nz_r <= prog0_nz_nxt;
    post_r <= post_nxt;
    cmd_r <= cmd_nxt;
    new_r <= new_nxt;
    res_status_r <= res_status_nxt;
    res_id_r <= res_id_nxt;
    res_addr_r <= res_addr_nxt;
    res_fin_r <= res_fin_nxt;
    out_status_r <= out_status_nxt;
    out_id_r <= out_id_nxt;
    out_addr_r <= out_addr_nxt;
    out_fin_r <= out_fin_nxt;
    out_count_r <= out_count_nxt;
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C) else $error("occupancy above table depth");

  a_head_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && occ_r != '0) |-> ({1'b0, head_r} < occ_r))
    else $error("head slot outside table");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready) else $error("request taken while busy");

  a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_CMP) |-> (i_r < j_r)) else $error("sort compares entry with itself");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && cmd_r == rqs_pkg::CMD_STEP) |->
      (res_status_r == rqs_pkg::ST_RAN || res_status_r == rqs_pkg::ST_EMPTY))
    else $error("step gave add status");

endmodule
